[hw/rtl/escape_time_point_colorizer_top_defines.svh]
// assertion macros for the escape time point colorizer
`ifndef ESCAPE_TIME_POINT_COLORIZER_TOP_DEFINES_SVH
`define ESCAPE_TIME_POINT_COLORIZER_TOP_DEFINES_SVH

// same-cycle implication
`define ETPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ETPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/etpc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package etpc_pkg;

  localparam int unsigned FracBits = 28;
  localparam int unsigned CountW   = 7;
  localparam int unsigned ColorW   = 8;

  localparam logic [CountW-1:0] IterLimit = 7'd80;
  localparam logic [CountW-1:0] BandLow   = 7'd20;
  localparam logic [CountW-1:0] BandMid   = 7'd40;

  localparam logic [ColorW-1:0] InsideRed   = 8'd2;
  localparam logic [ColorW-1:0] InsideGreen = 8'd255;
  localparam logic [ColorW-1:0] InsideBlue  = 8'd255;

  // |z|^2 escape bound, 4.0 with 2*FracBits fraction bits
  localparam logic [63:0] EscBound = 64'd4 << (2 * FracBits);

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic ready;
    logic done;
  } core_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x[63:31] == {33{1'b0}} || x[63:31] == {33{1'b1}}) begin
      res = x[31:0];
    end else if (x[63]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/etpc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface etpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_real;
  logic signed [31:0] point_imag;

  modport source (output valid, point_real, point_imag, input ready);
  modport sink (input valid, point_real, point_imag, output ready);
endinterface

`default_nettype wire

[hw/rtl/etpc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface etpc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] escape_count;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, escape_count, red, green, blue, input ready);
  modport sink (input valid, escape_count, red, green, blue, output ready);
endinterface

`default_nettype wire

[hw/rtl/etpc_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module etpc_mul import etpc_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hw/rtl/etpc_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module etpc_core import etpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] point_real_i,
  input  logic signed [31:0] point_imag_i,
  input  logic               take_i,
  output core_status_t       status_o,
  output logic [CountW-1:0]  count_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RR   = 6'b000010,
    S_II   = 6'b000100,
    S_RI   = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0]  n_q, n_d;
  logic signed [31:0] cr_q, ci_q;
  logic signed [31:0] zr_q, zi_q;
  logic signed [63:0] rr_q, ii_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [63:0]        mag;
  logic               escape;
  logic [CountW-1:0]  n_inc;
  logic signed [63:0] nr_full, ni_full;

  etpc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // operand select: zr*zr, zi*zi, zr*zi
  assign mul_a = (state_q == S_II) ? zi_q : zr_q;
  assign mul_b = (state_q == S_RR) ? zr_q : zi_q;

  assign mag     = $unsigned(rr_q) + $unsigned(prod);
  assign escape  = (mag >= EscBound);
  assign n_inc   = n_q + 1'b1;
  assign nr_full = ((rr_q - ii_q) >>> FracBits) + $signed({{32{cr_q[31]}}, cr_q});
  assign ni_full = (prod >>> (FracBits - 1)) + $signed({{32{ci_q[31]}}, ci_q});

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_RR;
          n_d     = '0;
        end
      end
      S_RR: state_d = S_II;
      S_II: state_d = S_RI;
      S_RI: state_d = escape ? S_DONE : S_UPD;
      S_UPD: begin
        n_d     = n_inc;
        state_d = (n_inc == IterLimit) ? S_DONE : S_RR;
      end
      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      cr_q <= point_real_i;
      ci_q <= point_imag_i;
      zr_q <= '0;
      zi_q <= '0;
    end
    if (state_q == S_II) begin
      rr_q <= prod;
    end
    if (state_q == S_RI) begin
      ii_q <= prod;
    end
    if (state_q == S_UPD) begin
      zr_q <= sat32(nr_full);
      zi_q <= sat32(ni_full);
    end
  end

  assign status_o.ready = (state_q == S_IDLE);
  assign status_o.done  = (state_q == S_DONE);
  assign count_o        = n_q;

endmodule

`default_nettype wire

[hw/rtl/etpc_color.sv]
`timescale 1ns / 1ps
`default_nettype none

module etpc_color import etpc_pkg::*; (
  input  logic [CountW-1:0] count_i,
  output rgb_t              rgb_o
);

  logic [9:0] n_ext;
  logic [9:0] n_x2, n_x3, n_x4, n_x6, n_x12;

  assign n_ext = {3'b000, count_i};
  assign n_x2  = n_ext << 1;
  assign n_x3  = n_x2 + n_ext;
  assign n_x4  = n_ext << 2;
  assign n_x6  = n_x3 << 1;
  assign n_x12 = n_x3 << 2;

  always_comb begin
    if (count_i < BandLow) begin
      rgb_o.red   = n_x3[7:0];
      rgb_o.green = n_x6[7:0];
      rgb_o.blue  = n_x12[7:0];
    end else if (count_i < BandMid) begin
      rgb_o.red   = n_x2[7:0];
      rgb_o.green = {3'b000, count_i[6:2]};
      rgb_o.blue  = n_x4[7:0];
    end else if (count_i == IterLimit) begin
      rgb_o.red   = InsideRed;
      rgb_o.green = InsideGreen;
      rgb_o.blue  = InsideBlue;
    end else begin
      rgb_o.red   = n_x3[7:0];
      rgb_o.green = {2'b00, count_i[6:1]};
      rgb_o.blue  = n_x2[7:0];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/escape_time_point_colorizer_top.sv]
// channel  | dir | payload
// in_i     | in  | point_real, point_imag (signed Q4.28)
// out_o    | out | escape_count, red, green, blue
//
// one item at a time
// each iteration steps through S_RR, S_II, S_RI and S_UPD around the one shared
// 32x32 multiplier (three products, then the update of z)
// reset clears the sequencer and the output valid flag
// a result waiting in the output register does not block the next item;
// a second result waits in the sequencer until the register is free
`timescale 1ns / 1ps
`default_nettype none

module escape_time_point_colorizer_top import etpc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  etpc_in_if.sink   in_i,
  etpc_out_if.source out_o
);

  core_status_t      status;
  logic [CountW-1:0] count;
  rgb_t              rgb;
  logic              take;

  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] count_q;
  rgb_t              rgb_q;

  etpc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_i.valid),
    .point_real_i (in_i.point_real),
    .point_imag_i (in_i.point_imag),
    .take_i       (take),
    .status_o     (status),
    .count_o      (count)
  );

  etpc_color u_color (
    .count_i (count),
    .rgb_o   (rgb)
  );

  assign in_i.ready = status.ready;
  assign take       = status.done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      count_q <= count;
      rgb_q   <= rgb;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.escape_count = count_q;
  assign out_o.red          = rgb_q.red;
  assign out_o.green        = rgb_q.green;
  assign out_o.blue         = rgb_q.blue;

endmodule

`default_nettype wire

[hw/rtl/etpc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "escape_time_point_colorizer_top_defines.svh"

module etpc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_i,
  input wire       out_valid_i,
  input wire       out_ready_i,
  input wire [6:0] escape_count_i,
  input wire [7:0] red_i,
  input wire [7:0] green_i,
  input wire [7:0] blue_i
);

  `ETPC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input ready right after an item")
  `ETPC_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_i, escape_count_i >= 7'd1 && escape_count_i <= 7'd80, "escape count out of range")
  `ETPC_ASSERT_NOW(a_inside_color, clk_i, rst_ni, out_valid_i && escape_count_i == 7'd80, red_i == 8'd2 && green_i == 8'd255 && blue_i == 8'd255, "wrong inside color")
  `ETPC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(escape_count_i) && $stable(red_i), "stalled item changed")

endmodule

bind escape_time_point_colorizer_top etpc_checker u_etpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .escape_count_i (out_o.escape_count),
  .red_i          (out_o.red),
  .green_i        (out_o.green),
  .blue_i         (out_o.blue)
);

`default_nettype wire

[sim/escape_time_point_colorizer_top_tb.sv]
`timescale 1ns / 1ps

module escape_time_point_colorizer_top_tb;
  import etpc_pkg::*;

  localparam int unsigned IdlePercent   = 38;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 400;
  localparam int unsigned MaxReports    = 10;

  localparam int QOne      = 1 << FracBits;
  localparam int QQuarter  = QOne / 4;
  localparam int QMaxInt   = 32'sh7fff_ffff;
  localparam int QMinInt   = 32'sh8000_0000;

  typedef struct packed {
    logic [CountW-1:0] count;
    rgb_t              color;
  } point_color_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  etpc_in_if  point_if ();
  etpc_out_if color_if ();

  escape_time_point_colorizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (point_if),
    .out_o  (color_if)
  );

  point_color_t pending_colors[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  bit           steady_flow    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [63:0] clamp_q(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7fff_ffff) begin
      return 64'sh0000_0000_7fff_ffff;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      return -64'sh0000_0000_8000_0000;
    end
    return x;
  endfunction

  function automatic point_color_t escape_color_of(input logic signed [31:0] cr,
                                                   input logic signed [31:0] ci);
    logic signed [63:0] zr, zi, rr, ii, ri;
    logic [63:0]        mag;
    int unsigned        steps;
    point_color_t       res;
    zr = 0;
    zi = 0;
    steps = 0;
    while (steps < IterLimit) begin
      rr  = zr * zr;
      ii  = zi * zi;
      mag = rr + ii;
      if (mag >= EscBound) break;
      ri = zr * zi;
      zr = clamp_q(((rr - ii) >>> FracBits) + cr);
      zi = clamp_q((ri >>> (FracBits - 1)) + ci);
      steps++;
    end
    res.count = steps[CountW-1:0];
    if (steps < BandLow) begin
      res.color.red   = 8'(3 * steps);
      res.color.green = 8'(6 * steps);
      res.color.blue  = 8'(12 * steps);
    end else if (steps < BandMid) begin
      res.color.red   = 8'(2 * steps);
      res.color.green = 8'(steps / 4);
      res.color.blue  = 8'(4 * steps);
    end else if (steps == IterLimit) begin
      res.color.red   = InsideRed;
      res.color.green = InsideGreen;
      res.color.blue  = InsideBlue;
    end else begin
      res.color.red   = 8'(3 * steps);
      res.color.green = 8'(steps / 2);
      res.color.blue  = 8'(2 * steps);
    end
    return res;
  endfunction

  // result side: random stalls, checking, and the watchdog
  always @(posedge clk_i) begin
    point_color_t want;
    if (rst_ni) begin
      if ((point_if.valid && point_if.ready) || (color_if.valid && color_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (color_if.valid && color_if.ready) begin
        if (pending_colors.size() == 0) begin
          if (mismatch_count < MaxReports) begin
            $display("%0t: unexpected item: count %0d rgb %0d %0d %0d", $time,
                     color_if.escape_count, color_if.red, color_if.green, color_if.blue);
          end
          mismatch_count++;
        end else begin
          want = pending_colors.pop_front();
          if (color_if.escape_count !== want.count || color_if.red !== want.color.red ||
              color_if.green !== want.color.green || color_if.blue !== want.color.blue) begin
            if (mismatch_count < MaxReports) begin
              $display("%0t: exp count %0d rgb %0d %0d %0d, got count %0d rgb %0d %0d %0d",
                       $time, want.count, want.color.red, want.color.green, want.color.blue,
                       color_if.escape_count, color_if.red, color_if.green, color_if.blue);
            end
            mismatch_count++;
          end
        end
      end
    end
    color_if.ready <= steady_flow || ($urandom_range(0, 99) >= IdlePercent);
  end

  task automatic send_point(input logic signed [31:0] cr, input logic signed [31:0] ci);
    while (!steady_flow && $urandom_range(0, 99) < IdlePercent) begin
      point_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    point_if.valid      <= 1'b1;
    point_if.point_real <= cr;
    point_if.point_imag <= ci;
    @(posedge clk_i);
    while (!point_if.ready) @(posedge clk_i);
    pending_colors.push_back(escape_color_of(cr, ci));
  endtask

  task automatic random_point(output logic signed [31:0] cr, output logic signed [31:0] ci);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // box around the whole set
      cr = int'($urandom_range(0, 2 * QOne + QOne / 2)) - 2 * QOne;
      ci = int'($urandom_range(0, 2 * (5 * QQuarter))) - 5 * QQuarter;
    end else if (pick < 75) begin
      // just past the cusp, slow escapes
      cr = QQuarter + int'($urandom_range(0, 1 << 22));
      ci = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    end else if (pick < 85) begin
      // the neck between the main bulbs
      cr = -3 * QQuarter + int'($urandom_range(0, 1 << 22)) - (1 << 21);
      ci = int'($urandom_range(0, 1 << 23)) - (1 << 22);
    end else begin
      cr = $urandom;
      ci = $urandom;
    end
  endtask

  task automatic test_extreme_points;
    send_point(0, 0);
    send_point(QMaxInt, QMaxInt);
    send_point(QMinInt, QMinInt);
    send_point(QMinInt, QMaxInt);
    send_point(QMaxInt, QMinInt);
    send_point(QMinInt, 0);
    send_point(0, QMaxInt);
    // on the escape circle, just inside it, then points nearer the origin
    send_point(-2 * QOne, 0);
    send_point(2 * QOne, 0);
    send_point(0, 2 * QOne);
    send_point(0, -2 * QOne);
    send_point(2 * QOne - 1, 0);
    send_point(-2 * QOne + 1, 0);
    send_point(0, QOne);
    send_point(QQuarter, 0);
    send_point(-3 * QQuarter, 0);
    send_point(-1, -1);
  endtask

  // walk the real axis past the cusp to hit the band edges
  task automatic test_band_edges;
    int unsigned targets[6] = '{19, 20, 39, 40, 79, 80};
    int lo, hi, mid;
    point_color_t probe;
    foreach (targets[t]) begin
      lo = 1;
      hi = QOne;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        probe = escape_color_of(QQuarter + mid, 0);
        if (probe.count >= targets[t]) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      send_point(QQuarter + lo, 0);
    end
  endtask

  task automatic test_random_points(input int unsigned count);
    logic signed [31:0] cr, ci;
    repeat (count) begin
      random_point(cr, ci);
      send_point(cr, ci);
    end
  endtask

  task automatic test_wild_points(input int unsigned count);
    repeat (count) begin
      send_point($urandom, $urandom);
    end
  endtask

  task automatic test_steady_flow(input int unsigned count);
    steady_flow = 1'b1;
    test_random_points(count);
    steady_flow = 1'b0;
  endtask

  task automatic test_drain_pause;
    test_random_points(25);
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_colors.size() != 0) @(posedge clk_i);
    test_random_points(25);
  endtask

  initial begin
    point_if.valid      = 1'b0;
    point_if.point_real = '0;
    point_if.point_imag = '0;
    color_if.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_points();
    test_band_edges();
    test_random_points(900);
    test_wild_points(150);
    test_steady_flow(200);
    test_drain_pause();

    point_if.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
